### rtl/core/lock_table_with_group_favoritism_top_defines.svh
// Assertion macros for the lock table
`ifndef LOCK_TABLE_WITH_GROUP_FAVORITISM_TOP_DEFINES_SVH
`define LOCK_TABLE_WITH_GROUP_FAVORITISM_TOP_DEFINES_SVH
`define LTGF_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lock table check failed");
`define LTGF_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lock table check failed");
`endif

### rtl/core/ltgf_pkg.sv
// Shared types and constants for the lock table
`timescale 1ns / 1ps
`default_nettype none
package ltgf_pkg;
   localparam int NUM_LOCKS   = 15;
   localparam int QUEUE_DEPTH = 16;
   localparam int LW = $clog2(NUM_LOCKS);
   localparam int QW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [6:0] MAX_FAVOR = 7'd100;

   typedef enum logic [1:0] {
      ACT_CREATE  = 2'd0,
      ACT_ACQUIRE = 2'd1,
      ACT_RELEASE = 2'd2,
      ACT_DESTROY = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_ERR    = 2'd1,
      ST_QUEUED = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      BS_IDLE, BS_SEARCH, BS_READ, BS_SHIFT, BS_REPLY, BS_GRANT
   } bstate_type;

   typedef struct packed {
      action_type  action;
      logic [3:0]  lock_id;
      logic [6:0]  favor;
      logic [15:0] pid;
      logic [7:0]  group;
      logic [6:0]  rnd;
   } item_type;
endpackage
`default_nettype wire

### rtl/core/ltgf_front.sv
// Front end: input skid buffer and a two-entry item queue
`timescale 1ns / 1ps
`default_nettype none
module ltgf_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire ltgf_pkg::item_type in_item,
   output logic                   q_valid,
   input  wire logic              q_ready,
   output ltgf_pkg::item_type     q_item
);
   ltgf_pkg::item_type buf_ff [2];
   logic rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic push, pop;

   assign in_ready = (cnt_ff != 2'd2);
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_item   = buf_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop  = q_valid && q_ready;

   always_comb begin
      rd_in  = pop ? ~rd_ff : rd_ff;
      wr_in  = push ? ~wr_ff : wr_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= 1'b0; wr_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         rd_ff <= rd_in; wr_ff <= wr_in; cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) buf_ff[wr_ff] <= in_item;
   end
endmodule
`default_nettype wire

### rtl/core/ltgf_back.sv
// Back end: lock state, waiter queues and result generation
`timescale 1ns / 1ps
`default_nettype none
`include "lock_table_with_group_favoritism_top_defines.svh"
module ltgf_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_valid,
   output logic                    q_ready,
   input  wire ltgf_pkg::item_type q_item,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_kind,
   output ltgf_pkg::status_type    rsp_status,
   output logic [3:0]              rsp_lock,
   output logic [15:0]             rsp_pid,
   output logic                    rsp_last
);
   localparam int N = ltgf_pkg::NUM_LOCKS;
   localparam int D = ltgf_pkg::QUEUE_DEPTH;
   localparam int LW = ltgf_pkg::LW;
   localparam int QW = ltgf_pkg::QW;
   localparam int CW = ltgf_pkg::CW;
   localparam int MW = LW + QW;

   logic [N-1:0] active_ff, held_ff;
   logic [15:0] owner_ff [N];
   logic [6:0] favor_ff [N];
   logic [CW-1:0] count_ff [N];
   logic [23:0] wmem [N*D];
   logic [23:0] rdata_ff;

   ltgf_pkg::bstate_type st_ff, st_in;
   ltgf_pkg::item_type it_ff;
   logic [LW-1:0] lk_ff;
   logic [CW-1:0] n_ff;
   logic [QW-1:0] idx_ff, pick_ff;
   logic [15:0] next_ff;
   logic found_ff, two_ff;
   ltgf_pkg::status_type st_res_ff;
   logic [3:0] res_lock_ff;
   logic out_v_ff, out_v_in, out_k_ff, out_l_ff;
   ltgf_pkg::status_type out_s_ff;
   logic [3:0] out_lk_ff;
   logic [15:0] out_pid_ff;

   logic [LW-1:0] free_slot;
   logic free_any, id_ok;
   logic [LW-1:0] qid;
   logic rd_en, wr_en;
   logic [MW-1:0] rd_addr, wr_addr;
   logic [23:0] wr_data;
   logic out_free;
   logic create_ok;
   ltgf_pkg::status_type res_st;
   logic [3:0] res_lk;

   assign qid = q_item.lock_id[LW-1:0];
   assign id_ok = ({{(LW+1){1'b0}}, q_item.lock_id} < (LW+5)'(N)) && active_ff[qid];
   assign out_free = !out_v_ff || rsp_ready;
   assign q_ready = (st_ff == ltgf_pkg::BS_IDLE);
   assign out_v_in = (out_v_ff && !rsp_ready)
                     || (out_free && (st_ff == ltgf_pkg::BS_REPLY
                                      || st_ff == ltgf_pkg::BS_GRANT));

   always_comb begin
      free_slot = '0;
      free_any = 1'b0;
      for (int i = N - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_slot = LW'(i);
            free_any = 1'b1;
         end
      end
   end

   always_comb begin
      create_ok = (q_item.favor <= ltgf_pkg::MAX_FAVOR) && free_any;
      res_lk = q_item.lock_id;
      res_st = ltgf_pkg::ST_ERR;
      case (q_item.action)
         ltgf_pkg::ACT_CREATE: begin
            res_lk = create_ok ? 4'(free_slot) : 4'd0;
            if (create_ok) res_st = ltgf_pkg::ST_OK;
         end
         ltgf_pkg::ACT_ACQUIRE: begin
            if (id_ok && !held_ff[qid])
               res_st = ltgf_pkg::ST_OK;
            else if (id_ok && count_ff[qid] < CW'(D))
               res_st = ltgf_pkg::ST_QUEUED;
         end
         ltgf_pkg::ACT_RELEASE: begin
            if (id_ok && held_ff[qid] && owner_ff[qid] == q_item.pid)
               res_st = ltgf_pkg::ST_OK;
         end
         ltgf_pkg::ACT_DESTROY: begin
            if (id_ok && !held_ff[qid]) res_st = ltgf_pkg::ST_OK;
         end
         default: ;
      endcase
   end

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ltgf_pkg::BS_IDLE: begin
            if (q_valid) begin
               if (q_item.action == ltgf_pkg::ACT_RELEASE && id_ok && held_ff[qid]
                   && owner_ff[qid] == q_item.pid && count_ff[qid] != '0)
                  st_in = ltgf_pkg::BS_SEARCH;
               else
                  st_in = ltgf_pkg::BS_REPLY;
            end
         end
         ltgf_pkg::BS_SEARCH: begin
            if (found_ff || favor_ff[lk_ff] == '0 || {1'b0, idx_ff} + 1'b1 >= n_ff
                || rdata_ff[7:0] == it_ff.group)
               st_in = ltgf_pkg::BS_READ;
         end
         ltgf_pkg::BS_READ:  st_in = ltgf_pkg::BS_SHIFT;
         ltgf_pkg::BS_SHIFT: begin
            if ({1'b0, idx_ff} + 1'b1 >= n_ff) st_in = ltgf_pkg::BS_REPLY;
         end
         ltgf_pkg::BS_REPLY: if (out_free) st_in = two_ff ? ltgf_pkg::BS_GRANT : ltgf_pkg::BS_IDLE;
         ltgf_pkg::BS_GRANT: if (out_free) st_in = ltgf_pkg::BS_IDLE;
         default: st_in = ltgf_pkg::BS_IDLE;
      endcase
   end

   always_comb begin
      rd_en = 1'b0;
      rd_addr = '0;
      wr_en = 1'b0;
      wr_addr = '0;
      wr_data = {it_ff.pid, it_ff.group};
      case (st_ff)
         ltgf_pkg::BS_IDLE: begin
            rd_en = q_valid;
            rd_addr = {qid, QW'(0)};
         end
         ltgf_pkg::BS_SEARCH: begin
            rd_en = 1'b1;
            rd_addr = {lk_ff, idx_ff + 1'b1};
         end
         ltgf_pkg::BS_READ: begin
            rd_en = 1'b1;
            rd_addr = {lk_ff, pick_ff};
         end
         ltgf_pkg::BS_SHIFT: begin
            rd_en = 1'b1;
            rd_addr = {lk_ff, idx_ff + 1'b1};
            wr_en = (idx_ff != pick_ff);
            wr_addr = {lk_ff, idx_ff - 1'b1};
            wr_data = rdata_ff;
         end
         ltgf_pkg::BS_REPLY: begin
            wr_en = out_free && it_ff.action == ltgf_pkg::ACT_ACQUIRE
                    && st_res_ff == ltgf_pkg::ST_QUEUED;
            wr_addr = {lk_ff, n_ff[QW-1:0]};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (rd_en) rdata_ff <= wmem[rd_addr];
      if (wr_en) wmem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ltgf_pkg::BS_IDLE;
         active_ff <= '0;
         held_ff <= '0;
         out_v_ff <= 1'b0;
         for (int i = 0; i < N; i++) begin
            owner_ff[i] <= '0; favor_ff[i] <= '0; count_ff[i] <= '0;
         end
      end else begin
         st_ff <= st_in;
         out_v_ff <= out_v_in;
         case (st_ff)
            ltgf_pkg::BS_IDLE: if (q_valid) begin
               it_ff <= q_item;
               lk_ff <= qid;
               n_ff <= count_ff[qid];
               idx_ff <= '0;
               pick_ff <= '0;
               found_ff <= 1'b0;
               two_ff <= (st_in == ltgf_pkg::BS_SEARCH);
               res_lock_ff <= res_lk;
               st_res_ff <= res_st;
               case (q_item.action)
                  ltgf_pkg::ACT_CREATE: begin
                     if (create_ok) begin
                        active_ff[free_slot] <= 1'b1;
                        held_ff[free_slot] <= 1'b0;
                        owner_ff[free_slot] <= '0;
                        favor_ff[free_slot] <= q_item.favor;
                        count_ff[free_slot] <= '0;
                     end
                  end
                  ltgf_pkg::ACT_ACQUIRE: begin
                     if (res_st == ltgf_pkg::ST_OK) begin
                        held_ff[qid] <= 1'b1;
                        owner_ff[qid] <= q_item.pid;
                     end else if (res_st == ltgf_pkg::ST_QUEUED) begin
                        count_ff[qid] <= count_ff[qid] + 1'b1;
                     end
                  end
                  ltgf_pkg::ACT_RELEASE: begin
                     if (res_st == ltgf_pkg::ST_OK) begin
                        if (count_ff[qid] == '0) begin
                           held_ff[qid] <= 1'b0;
                           owner_ff[qid] <= '0;
                        end else begin
                           count_ff[qid] <= count_ff[qid] - 1'b1;
                        end
                     end
                  end
                  ltgf_pkg::ACT_DESTROY: begin
                     if (res_st == ltgf_pkg::ST_OK) begin
                        active_ff[qid] <= 1'b0;
                        owner_ff[qid] <= '0;
                        count_ff[qid] <= '0;
                     end
                  end
                  default: ;
               endcase
            end
            ltgf_pkg::BS_SEARCH: begin
               if (!found_ff && favor_ff[lk_ff] != '0 && rdata_ff[7:0] == it_ff.group) begin
                  found_ff <= 1'b1;
                  if (it_ff.rnd < favor_ff[lk_ff]) pick_ff <= idx_ff;
               end
               idx_ff <= idx_ff + 1'b1;
            end
            ltgf_pkg::BS_READ: idx_ff <= pick_ff;
            ltgf_pkg::BS_SHIFT: begin
               if (idx_ff == pick_ff) begin
                  next_ff <= rdata_ff[23:8];
                  owner_ff[lk_ff] <= rdata_ff[23:8];
               end
               idx_ff <= idx_ff + 1'b1;
            end
            ltgf_pkg::BS_REPLY: if (out_free) begin
               out_k_ff <= 1'b0;
               out_s_ff <= st_res_ff;
               out_lk_ff <= res_lock_ff;
               out_pid_ff <= it_ff.pid;
               out_l_ff <= !two_ff;
            end
            ltgf_pkg::BS_GRANT: if (out_free) begin
               out_k_ff <= 1'b1;
               out_s_ff <= ltgf_pkg::ST_OK;
               out_lk_ff <= res_lock_ff;
               out_pid_ff <= next_ff;
               out_l_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_kind = out_k_ff;
   assign rsp_status = out_s_ff;
   assign rsp_lock = out_lk_ff;
   assign rsp_pid = out_pid_ff;
   assign rsp_last = out_l_ff;

   `LTGF_ASSERT_IMPL(a_held_active, 1'b1, (held_ff & ~active_ff) == '0)
   `LTGF_ASSERT_NEXT(a_hold_out, out_v_ff && !rsp_ready, out_v_ff && $stable(out_pid_ff))
   `LTGF_ASSERT_IMPL(a_grant_kind, out_v_ff && out_k_ff, out_l_ff)
endmodule
`default_nettype wire

### rtl/core/lock_table_with_group_favoritism_top.sv
// Lock table top: front queue and back-end executor
// A release with waiters holds the back end while it searches the waiter queue and then
// shifts the entries behind the pick, one entry per cycle; no new item is taken until
// its replies have been loaded into the output register.
// Reset: synchronous, clears all lock flags, counts and the item queue.
// Waiter memory is not cleared; entries past a lock's count may be read but are never used.
`timescale 1ns / 1ps
`default_nettype none
module lock_table_with_group_favoritism_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // action[1:0], lock_id[5:2], lock_favoritism[12:6], requester_id[28:13],
   // requester_group[36:29], random_percent[43:37]
   input  wire logic [47:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // kind[0], status[2:1], result_lock[6:3], result_pid[22:7]
   output logic [23:0]      rsp_tdata,
   output logic             rsp_tlast
);
   ltgf_pkg::item_type in_item, q_item;
   logic q_valid, q_ready, kind;
   ltgf_pkg::status_type status;
   logic [3:0] lk;
   logic [15:0] pid;

   assign in_item.action = ltgf_pkg::action_type'(req_tdata[1:0]);
   assign in_item.lock_id = req_tdata[5:2];
   assign in_item.favor = req_tdata[12:6];
   assign in_item.pid = req_tdata[28:13];
   assign in_item.group = req_tdata[36:29];
   assign in_item.rnd = req_tdata[43:37];

   ltgf_front u_front (
      .clock(clock), .reset(reset), .in_valid(req_tvalid), .in_ready(req_tready),
      .in_item(in_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
   );

   ltgf_back u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_ready(q_ready),
      .q_item(q_item), .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready),
      .rsp_kind(kind), .rsp_status(status), .rsp_lock(lk), .rsp_pid(pid),
      .rsp_last(rsp_tlast)
   );

   assign rsp_tdata = {1'b0, pid, lk, status, kind};
endmodule
`default_nettype wire

### sim/tb_lock_table_with_group_favoritism_top.sv
// Testbench for the lock table: random and directed lock requests checked by a scoreboard
`timescale 1ns / 1ps
`default_nettype none
module tb_lock_table_with_group_favoritism_top;

   typedef struct packed {
      logic       kind;
      ltgf_pkg::status_type status;
      logic [3:0] lock_no;
      logic [15:0] pid;
      logic       last;
   } grant_reply_type;

   class lock_scoreboard;
      bit          active [ltgf_pkg::NUM_LOCKS];
      bit          held [ltgf_pkg::NUM_LOCKS];
      logic [15:0] owner [ltgf_pkg::NUM_LOCKS];
      logic [6:0]  favor [ltgf_pkg::NUM_LOCKS];
      int          count [ltgf_pkg::NUM_LOCKS];
      logic [15:0] wid [ltgf_pkg::NUM_LOCKS][ltgf_pkg::QUEUE_DEPTH];
      logic [7:0]  wgrp [ltgf_pkg::NUM_LOCKS][ltgf_pkg::QUEUE_DEPTH];
      grant_reply_type pending_replies[$];
      int          errors;

      task report_mismatch(string what);
         $display("error at %0t: %s", $realtime, what);
         errors++;
      endtask

      function void push(logic k, ltgf_pkg::status_type s, logic [3:0] l,
                         logic [15:0] p, logic la);
         grant_reply_type r;
         r.kind = k; r.status = s; r.lock_no = l; r.pid = p; r.last = la;
         pending_replies.push_back(r);
      endfunction

      function void note_request(ltgf_pkg::item_type it);
         int i, n, pick, id;
         logic [15:0] nxt;
         id = int'(it.lock_id);
         if (it.action == ltgf_pkg::ACT_CREATE) begin
            if (it.favor <= ltgf_pkg::MAX_FAVOR) begin
               for (i = 0; i < ltgf_pkg::NUM_LOCKS; i++) begin
                  if (!active[i]) begin
                     active[i] = 1; held[i] = 0; owner[i] = '0;
                     favor[i] = it.favor; count[i] = 0;
                     push(1'b0, ltgf_pkg::ST_OK, i[3:0], it.pid, 1'b1);
                     return;
                  end
               end
            end
            push(1'b0, ltgf_pkg::ST_ERR, 4'd0, it.pid, 1'b1);
            return;
         end
         if (id >= ltgf_pkg::NUM_LOCKS || !active[id]) begin
            push(1'b0, ltgf_pkg::ST_ERR, it.lock_id, it.pid, 1'b1);
            return;
         end
         case (it.action)
            ltgf_pkg::ACT_ACQUIRE: begin
               if (!held[id]) begin
                  held[id] = 1; owner[id] = it.pid;
                  push(1'b0, ltgf_pkg::ST_OK, it.lock_id, it.pid, 1'b1);
               end else if (count[id] >= ltgf_pkg::QUEUE_DEPTH) begin
                  push(1'b0, ltgf_pkg::ST_ERR, it.lock_id, it.pid, 1'b1);
               end else begin
                  wid[id][count[id]] = it.pid;
                  wgrp[id][count[id]] = it.group;
                  count[id]++;
                  push(1'b0, ltgf_pkg::ST_QUEUED, it.lock_id, it.pid, 1'b1);
               end
            end
            ltgf_pkg::ACT_RELEASE: begin
               n = count[id];
               pick = 0;
               if (!held[id] || owner[id] != it.pid) begin
                  push(1'b0, ltgf_pkg::ST_ERR, it.lock_id, it.pid, 1'b1);
               end else if (n == 0) begin
                  held[id] = 0; owner[id] = '0;
                  push(1'b0, ltgf_pkg::ST_OK, it.lock_id, it.pid, 1'b1);
               end else begin
                  if (favor[id] > 0) begin
                     for (i = 0; i < n; i++) begin
                        if (wgrp[id][i] == it.group) begin
                           if (it.rnd < favor[id]) pick = i;
                           break;
                        end
                     end
                  end
                  nxt = wid[id][pick];
                  for (i = pick + 1; i < n; i++) begin
                     wid[id][i-1] = wid[id][i];
                     wgrp[id][i-1] = wgrp[id][i];
                  end
                  count[id] = n - 1;
                  owner[id] = nxt;
                  push(1'b0, ltgf_pkg::ST_OK, it.lock_id, it.pid, 1'b0);
                  push(1'b1, ltgf_pkg::ST_OK, it.lock_id, nxt, 1'b1);
               end
            end
            default: begin
               if (held[id]) begin
                  push(1'b0, ltgf_pkg::ST_ERR, it.lock_id, it.pid, 1'b1);
               end else begin
                  active[id] = 0; owner[id] = '0; count[id] = 0;
                  push(1'b0, ltgf_pkg::ST_OK, it.lock_id, it.pid, 1'b1);
               end
            end
         endcase
      endfunction

      task check_reply(logic [23:0] d, logic la);
         grant_reply_type e;
         if (pending_replies.size() == 0) begin
            report_mismatch("reply with nothing expected");
            return;
         end
         e = pending_replies.pop_front();
         if (d[0] !== e.kind) report_mismatch("kind");
         if (d[2:1] !== e.status) report_mismatch("status");
         if (d[6:3] !== e.lock_no) report_mismatch("result_lock");
         if (d[22:7] !== e.pid) report_mismatch("result_pid");
         if (la !== e.last) report_mismatch("last");
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [47:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [23:0] rsp_tdata;
   logic rsp_tlast;

   lock_scoreboard board = new();
   int send_idle = 0;
   int recv_idle = 0;
   bit hold_off = 0;
   int lock_no_pool = 4;
   logic [15:0] pid_pool [4] = '{16'h0000, 16'hFFFF, 16'h1234, 16'h8001};

   lock_table_with_group_favoritism_top u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   task automatic send_request(ltgf_pkg::action_type a, logic [3:0] l, logic [6:0] f,
                               logic [15:0] p, logic [7:0] g, logic [6:0] r);
      ltgf_pkg::item_type it;
      it.action = a; it.lock_id = l; it.favor = f; it.pid = p; it.group = g; it.rnd = r;
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {4'd0, it.rnd, it.group, it.pid, it.favor, it.lock_id, it.action};
      do @(posedge clock); while (!req_tready);
      board.note_request(it);
      @(negedge clock);
   endtask

   task automatic send_random;
      int sel;
      ltgf_pkg::action_type a;
      logic [3:0] l;
      logic [6:0] f, r;
      logic [15:0] p;
      logic [7:0] g;
      sel = $urandom_range(99);
      a = ltgf_pkg::action_type'($urandom_range(3));
      if (sel < 10) a = ltgf_pkg::ACT_CREATE;
      l = (sel < 95) ? 4'($urandom_range(lock_no_pool - 1)) : 4'($urandom_range(15));
      f = (sel < 90) ? 7'($urandom_range(100)) : 7'($urandom_range(127));
      p = (sel < 85) ? pid_pool[$urandom_range(3)] : 16'($urandom_range(16'hFFFF));
      if (a == ltgf_pkg::ACT_RELEASE && sel < 70 && board.held[l % ltgf_pkg::NUM_LOCKS])
         p = board.owner[l % ltgf_pkg::NUM_LOCKS];
      r = (sel < 95) ? 7'($urandom_range(99)) : 7'($urandom_range(127));
      g = (sel < 60) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
      send_request(a, l, f, p, g, r);
   endtask

   always @(negedge clock) begin
      rsp_tready <= !hold_off && ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_reply(rsp_tdata, rsp_tlast);
   end

   initial begin
      #50_000_000;
      $display("lock_table_with_group_favoritism_top: mismatch");
      $finish;
   end

   initial begin
      int i, k;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      send_request(ltgf_pkg::ACT_CREATE, 4'd0, 7'd101, 16'h0001, 8'd0, 7'd0);
      send_request(ltgf_pkg::ACT_CREATE, 4'd0, 7'd127, 16'h0001, 8'd0, 7'd0);
      send_request(ltgf_pkg::ACT_CREATE, 4'd0, 7'd100, 16'h0002, 8'd0, 7'd0);
      send_request(ltgf_pkg::ACT_CREATE, 4'd0, 7'd0, 16'h0003, 8'd0, 7'd0);
      send_request(ltgf_pkg::ACT_ACQUIRE, 4'd15, 7'd0, 16'hFFFF, 8'hFF, 7'd0);
      send_request(ltgf_pkg::ACT_RELEASE, 4'd1, 7'd0, 16'h0009, 8'd0, 7'd0);
      send_request(ltgf_pkg::ACT_ACQUIRE, 4'd0, 7'd0, 16'h0010, 8'd1, 7'd0);
      send_request(ltgf_pkg::ACT_ACQUIRE, 4'd0, 7'd0, 16'h0010, 8'd1, 7'd0);
      send_request(ltgf_pkg::ACT_ACQUIRE, 4'd0, 7'd0, 16'h0011, 8'd2, 7'd0);
      send_request(ltgf_pkg::ACT_DESTROY, 4'd0, 7'd0, 16'h0011, 8'd2, 7'd0);
      send_request(ltgf_pkg::ACT_RELEASE, 4'd0, 7'd0, 16'h0022, 8'd2, 7'd0);
      send_request(ltgf_pkg::ACT_RELEASE, 4'd0, 7'd0, 16'h0010, 8'd2, 7'd99);
      send_request(ltgf_pkg::ACT_RELEASE, 4'd0, 7'd0, 16'h0010, 8'd2, 7'd127);
      send_request(ltgf_pkg::ACT_RELEASE, 4'd0, 7'd0, 16'h0011, 8'd2, 7'd0);
      send_request(ltgf_pkg::ACT_DESTROY, 4'd0, 7'd0, 16'h0011, 8'd2, 7'd0);
      send_request(ltgf_pkg::ACT_DESTROY, 4'd14, 7'd0, 16'h0011, 8'd2, 7'd0);
      for (i = 0; i < 16; i++)
         send_request(ltgf_pkg::ACT_CREATE, 4'd0, 7'd50, 16'h0100, 8'd0, 7'd0);
      send_request(ltgf_pkg::ACT_ACQUIRE, 4'd14, 7'd0, 16'h0001, 8'd0, 7'd0);
      for (i = 0; i < 17; i++)
         send_request(ltgf_pkg::ACT_ACQUIRE, 4'd14, 7'd0, i[15:0], i[7:0], 7'd0);
      send_request(ltgf_pkg::ACT_RELEASE, 4'd14, 7'd0, 16'h0001, 8'd5, 7'd0);
      for (k = 0; k < 3; k++) begin
         send_idle = (k == 0) ? 32 : (k == 1) ? 87 : 0;
         recv_idle = (k == 0) ? 87 : (k == 1) ? 32 : 0;
         if (k == 2) begin
            fork
               begin
                  hold_off = 1;
                  repeat (400) @(negedge clock);
                  hold_off = 0;
               end
               for (i = 0; i < 40; i++) send_random();
            join
         end
         for (i = 0; i < 300; i++) begin
            lock_no_pool = (i < 150) ? 4 : 15;
            send_random();
         end
      end
      req_tvalid <= 0;
      i = 0;
      while (board.pending_replies.size() != 0 && i < 100000) begin
         @(negedge clock);
         i++;
      end
      repeat (50) @(negedge clock);
      if (board.errors == 0 && board.pending_replies.size() == 0) begin
         $display("lock_table_with_group_favoritism_top: match");
      end else begin
         $display("lock_table_with_group_favoritism_top: mismatch");
      end
      $finish;
   end
endmodule
`default_nettype wire
